@@ rtl/core/aeui_pkg.sv @@
// Package with the item types and constants of the unwind interpreter.
package aeui_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE_REG = 2'd0,
        FUNC_BEGIN     = 2'd1,
        FUNC_TABLE     = 2'd2,
        FUNC_STACK     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_FETCH  = 2'd0,
        KIND_STACK  = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  reg_index;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] pc_out;
        logic [31:0] sp_out;
        logic [31:0] lr_out;
        logic [15:0] restore_mask;
        logic        more;
    } t_out_item;

    localparam logic [0:0] REG_STACK_BASE = 1'b0;
    localparam logic [0:0] REG_STACK_SIZE = 1'b1;

    localparam logic [31:0] HDR_SHORT    = 32'h8000_0000;
    localparam logic [31:0] HDR_LONG     = 32'h8100_0000;
    localparam logic [31:0] CANT_UNWIND  = 32'h0000_0001;
    localparam logic [31:0] LARGE_INC    = 32'h0000_0204;
    localparam logic [7:0]  OP_FINISH    = 8'hb0;
    localparam logic [7:0]  OP_POP_LOW   = 8'hb1;
    localparam logic [7:0]  OP_LARGE_INC = 8'hb2;

endpackage

@@ rtl/core/arm_eh_unwind_interpreter.sv @@
// Top level of the single-frame ARM exception-table unwind interpreter.

// Each input item is handled by a small sequencer over one shared 32-bit adder and a stack
// bounds check. A register write is done at the edge that accepts it. A begin frame,
// table word or stack word item then passes a dispatch and a decode state for each opcode
// byte, a dispatch and an operand state for each operand byte, a bounds check and the
// request for each stack pop, a dispatch or decode state to issue a table word request,
// and dispatch, PC fix-up, result and a closing state to finish. The block is not ready
// while an item is in work or while its result waits in the output register. Requests for
// table words and stack words leave as result items.
module arm_eh_unwind_interpreter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  aeui_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output aeui_pkg::t_out_item   o_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import aeui_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RUN, S_DECODE, S_ARG, S_POPCHK, S_POPADDR, S_FINOK, S_FIN,
        S_OUT, S_WOPWORD, S_WARGWORD, S_WSTACK
    } t_state;

    t_state       r_state;
    logic [31:0]  r_base, r_size;
    logic [31:0]  r_rf [16];
    logic [31:0]  r_start_pc, r_word, r_wsp;
    logic [15:0]  r_mask;
    logic [1:0]   r_bpos;
    logic [8:0]   r_left;
    logic [7:0]   r_op, r_arg;
    logic [11:0]  r_bits;
    logic [3:0]   r_cursor;
    logic         r_need, r_keep, r_ok, r_argpend;
    t_out_item    r_out;
    logic         r_ovalid;

    logic [7:0]   w_byte;
    logic [31:0]  w_add_a, w_add_b, w_sum;
    logic [3:0]   w_first;
    logic [32:0]  w_hi, w_end;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? r_size : r_base;
    assign o_ready = (r_state == S_IDLE || r_state == S_WOPWORD || r_state == S_WARGWORD
                      || r_state == S_WSTACK) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_item = r_out;

    assign w_byte = r_word[{r_bpos, 3'b000} +: 8];
    assign w_sum = w_add_a + w_add_b;
    assign w_hi = {1'b0, r_base} + {1'b0, r_size};
    assign w_end = {1'b0, r_wsp} + 33'd4;

    always_comb begin
        w_first = 4'd0;
        for (int k = 11; k >= 0; k--) begin
            if (r_bits[k]) begin
                w_first = 4'(k);
            end
        end
    end

    // The shared adder: SP updates, pop addresses and large increments.
    always_comb begin
        w_add_a = r_rf[13];
        w_add_b = 32'd0;
        case (r_state)
            S_DECODE: begin
                if (w_byte[7:6] == 2'b00) begin
                    w_add_b = {24'd0, w_byte[5:0], 2'b00} + 32'd4;
                end else begin
                    w_add_b = ~({24'd0, w_byte[5:0], 2'b00} + 32'd4) + 32'd1;
                end
            end
            S_ARG: begin
                w_add_b = LARGE_INC + {22'd0, r_arg, 2'b00};
            end
            S_WSTACK: begin
                w_add_a = r_wsp;
                w_add_b = 32'd4;
            end
            default: begin
                w_add_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base <= '0;
            r_size <= '0;
            for (int k = 0; k < 16; k++) begin
                r_rf[k] <= '0;
            end
            r_start_pc <= '0;
            r_word <= '0;
            r_wsp <= '0;
            r_mask <= '0;
            r_bpos <= '0;
            r_left <= '0;
            r_op <= '0;
            r_arg <= '0;
            r_bits <= '0;
            r_cursor <= '0;
            r_need <= 1'b0;
            r_keep <= 1'b0;
            r_ok <= 1'b0;
            r_argpend <= 1'b0;
            r_ovalid <= 1'b0;
            r_out <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_STACK_BASE) begin
                    r_base <= pwdata;
                end else begin
                    r_size <= pwdata;
                end
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_valid && o_ready) begin
                case (t_func'(i_item.func))
                    FUNC_WRITE_REG: begin
                        r_rf[i_item.reg_index] <= i_item.value;
                    end
                    FUNC_BEGIN: begin
                        r_mask <= '0;
                        r_start_pc <= r_rf[15];
                        if (i_item.value == CANT_UNWIND) begin
                            r_ok <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_rf[15] <= '0;
                            r_word <= i_item.value;
                            r_need <= 1'b0;
                            if ((i_item.value & 32'hff00_0000) == HDR_SHORT) begin
                                r_bpos <= 2'd2;
                                r_left <= 9'd1;
                                r_state <= S_RUN;
                            end else if ((i_item.value & 32'hff00_0000) == HDR_LONG) begin
                                r_bpos <= 2'd1;
                                r_left <= {1'b0, i_item.value[23:16]} + 9'd1;
                                r_state <= S_RUN;
                            end else begin
                                r_ok <= 1'b0;
                                r_state <= S_FIN;
                            end
                        end
                    end
                    FUNC_TABLE: begin
                        if (r_state == S_WOPWORD || r_state == S_WARGWORD) begin
                            r_word <= i_item.value;
                            r_need <= 1'b0;
                            r_argpend <= (r_state == S_WARGWORD);
                            r_state <= S_RUN;
                        end
                    end
                    FUNC_STACK: begin
                        if (r_state == S_WSTACK) begin
                            r_rf[r_cursor] <= i_item.value;
                            if (!(r_op[7:3] == 5'b10101 && r_cursor == 4'd14)) begin
                                r_mask[r_cursor] <= 1'b1;
                            end
                            if (r_cursor == 4'd13) begin
                                r_keep <= 1'b1;
                            end
                            r_bits[r_cursor - ((r_op == OP_POP_LOW) ? 4'd0 : 4'd4)] <= 1'b0;
                            r_wsp <= w_sum;
                            r_state <= S_POPCHK;
                        end
                    end
                    default: begin
                        r_state <= r_state;
                    end
                endcase
            end else begin
                case (r_state)
                    S_RUN: begin
                        if (r_argpend) begin
                            r_argpend <= 1'b0;
                            r_arg <= w_byte;
                            if (r_bpos == 2'd0) begin
                                r_bpos <= 2'd3;
                                r_need <= 1'b1;
                                if (r_left != 9'd0) r_left <= r_left - 9'd1;
                            end else begin
                                r_bpos <= r_bpos - 2'd1;
                            end
                            r_state <= S_ARG;
                        end else if (r_left == 9'd0) begin
                            r_state <= S_FINOK;
                        end else if (r_need) begin
                            r_out <= '{kind: KIND_FETCH, default: '0};
                            r_ovalid <= 1'b1;
                            r_state <= S_WOPWORD;
                        end else begin
                            r_state <= S_DECODE;
                        end
                    end
                    S_DECODE: begin
                        if (r_bpos == 2'd0) begin
                            r_bpos <= 2'd3;
                            r_need <= 1'b1;
                            if (r_left != 9'd0) r_left <= r_left - 9'd1;
                        end else begin
                            r_bpos <= r_bpos - 2'd1;
                        end
                        r_state <= S_RUN;
                        if (w_byte[7] == 1'b0) begin
                            r_rf[13] <= w_sum;
                        end else if (w_byte[7:4] == 4'h9 && w_byte[3:0] != 4'd13
                                     && w_byte[3:0] != 4'd15) begin
                            r_rf[13] <= r_rf[w_byte[3:0]];
                        end else if (w_byte[7:4] == 4'ha) begin
                            r_op <= w_byte;
                            r_bits <= {1'b0, w_byte[3], 10'd0}
                                      | ~(12'hfff << ({1'b0, w_byte[2:0]} + 4'd1));
                            r_keep <= 1'b0;
                            r_wsp <= r_rf[13];
                            r_state <= S_POPCHK;
                        end else if (w_byte == OP_FINISH) begin
                            r_left <= '0;
                        end else if (w_byte[7:4] == 4'h8 || w_byte == OP_POP_LOW
                                     || w_byte == OP_LARGE_INC) begin
                            r_op <= w_byte;
                            if (r_bpos == 2'd0) begin
                                r_argpend <= 1'b0;
                                r_out <= '{kind: KIND_FETCH, default: '0};
                                r_ovalid <= 1'b1;
                                r_state <= S_WARGWORD;
                            end else begin
                                r_argpend <= 1'b1;
                            end
                        end else begin
                            r_ok <= 1'b0;
                            r_state <= S_FIN;
                        end
                    end
                    S_ARG: begin
                        r_keep <= 1'b0;
                        r_wsp <= r_rf[13];
                        if (r_op[7:4] == 4'h8) begin
                            r_bits <= {r_op[3:0], r_arg};
                            if ({r_op[3:0], r_arg} == 12'd0) begin
                                r_ok <= 1'b0;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_POPCHK;
                            end
                        end else if (r_op == OP_POP_LOW) begin
                            r_bits <= {4'd0, r_arg};
                            if (r_arg == 8'd0 || r_arg[7:4] != 4'd0) begin
                                r_ok <= 1'b0;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_POPCHK;
                            end
                        end else begin
                            r_rf[13] <= w_sum;
                            r_state <= S_RUN;
                        end
                    end
                    S_POPCHK: begin
                        if (r_bits == 12'd0) begin
                            if (!r_keep) r_rf[13] <= r_wsp;
                            r_state <= S_RUN;
                        end else if (r_wsp < r_base || w_end > w_hi) begin
                            r_ok <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_POPADDR;
                        end
                    end
                    S_POPADDR: begin
                        r_cursor <= w_first + ((r_op == OP_POP_LOW) ? 4'd0 : 4'd4);
                        r_out <= '{kind: KIND_STACK, address: r_wsp, default: '0};
                        r_ovalid <= 1'b1;
                        r_state <= S_WSTACK;
                    end
                    S_FINOK: begin
                        if (r_rf[15] == 32'd0) begin
                            r_rf[15] <= r_rf[14];
                            if (r_start_pc != r_rf[14]) r_mask[15] <= 1'b1;
                        end
                        r_ok <= 1'b1;
                        r_state <= S_FIN;
                    end
                    S_FIN: begin
                        r_out <= '{kind: KIND_FINISH, address: 32'd0, pc_out: r_rf[15],
                                   sp_out: r_rf[13], lr_out: r_rf[14],
                                   restore_mask: r_mask, more: r_ok};
                        r_ovalid <= 1'b1;
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        r_state <= S_IDLE;
                    end
                    default: begin
                        r_state <= r_state;
                    end
                endcase
            end
        end
    end
endmodule
